/* hw/rtl/llr_k_min_select_normalize_defines.svh */
// Assertion macros shared by the LLR k-min select and normalise block.
`ifndef LLR_K_MIN_SELECT_NORMALIZE_DEFINES_SVH
`define LLR_K_MIN_SELECT_NORMALIZE_DEFINES_SVH

// Clocked assertion of a property, disabled while reset is asserted.
`define LLRK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion of an overlapping implication.
`define LLRK_ASSERT_IMPL(lbl, ante, cons, msg) \
  `LLRK_ASSERT(lbl, (ante) |-> (cons), msg)

// Clocked assertion of a next-cycle implication.
`define LLRK_ASSERT_NEXT(lbl, ante, cons, msg) \
  `LLRK_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* hw/rtl/llrk_pkg.sv */
// Package with the constants, word types, cell control type and state type of the block.
package llrk_pkg;

  localparam int FIELD_SIZE = 64;
  localparam int MAX_KEEP   = 64;

  localparam int LLR_W  = 16;
  localparam int SYM_W  = 6;
  localparam int KEEP_W = 7;
  localparam int CNT_W  = $clog2(FIELD_SIZE + 1);
  localparam int CAP_W  = $clog2(MAX_KEEP + 1);
  localparam int CMP_W  = (CAP_W > KEEP_W) ? CAP_W : KEEP_W;

  localparam logic [KEEP_W-1:0] KEEP_RST = KEEP_W'(16);

  typedef struct packed {
    logic signed [LLR_W-1:0] llr_value;
    logic                    is_last;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [LLR_W-1:0] norm_llr;
    logic             last_out;
  } out_word_t;

  typedef struct packed {
    logic signed [LLR_W-1:0] llr;
    logic [SYM_W-1:0]        sym;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_FILL = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

/* hw/rtl/llr_k_min_select_normalize.sv */
// Top level: keeps the smallest LLRs of a message sorted and emits them normalised.
// Each input word's LLR is compared with every cell of a sorted row of MAX_KEEP cells at
// once and inserted in place, the larger entries moving one cell down.
// On the word marked last the block stops taking input and shifts the kept entries out of
// the head cell, one output word per cycle while the output is ready, each minus the
// smallest one. There is no clearing pass after reset; the cells are ready at once.
`include "llr_k_min_select_normalize_defines.svh"
module llr_k_min_select_normalize import llrk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [KEEP_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o
);

  logic [KEEP_W-1:0] keep_count_q;
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  sym_cnt_q, sym_cnt_d;
  logic [CAP_W-1:0]  emit_cnt_q, emit_cnt_d;
  logic              first_q, first_d;
  logic [LLR_W-1:0]  base_q, base_d;

  logic [CMP_W-1:0]  keep_wide;
  logic [CAP_W-1:0]  cap;
  logic [MAX_KEEP-1:0] in_cap;
  logic [MAX_KEEP:0] keep_ext;
  logic [MAX_KEEP:0] valid_ext;
  entry_t            entry_ext [MAX_KEEP+1];
  entry_t            new_entry;
  cell_ctrl_t        ctrl;

  logic              accept_in, accept_out, do_insert, out_last;
  logic [LLR_W-1:0]  base_eff;

  assign keep_wide = CMP_W'(keep_count_q);
  assign cap = (keep_count_q == '0) ? CAP_W'(1) :
               ((keep_wide > CMP_W'(MAX_KEEP)) ? CAP_W'(MAX_KEEP) : CAP_W'(keep_wide));

  assign in_ready_o  = (state_q == ST_FILL);
  assign out_valid_o = (state_q == ST_EMIT);
  assign accept_in   = in_valid_i && in_ready_o;
  assign accept_out  = out_valid_o && out_ready_i;
  assign do_insert   = accept_in && (sym_cnt_q < CNT_W'(FIELD_SIZE));
  assign out_last    = ((emit_cnt_q + CAP_W'(1)) == cap) || !valid_ext[1];

  assign new_entry.llr = in_word_i.llr_value;
  assign new_entry.sym = SYM_W'(sym_cnt_q);

  assign ctrl.insert = do_insert;
  assign ctrl.shift  = accept_out && !out_last;
  assign ctrl.clear  = accept_out && out_last;

  assign keep_ext[0]          = 1'b1;
  assign valid_ext[MAX_KEEP]  = 1'b0;
  assign entry_ext[MAX_KEEP]  = '0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    assign in_cap[i] = (CAP_W'(i) < cap);

    llrk_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_i       (new_entry),
      .in_cap_i    (in_cap[i]),
      .prev_keep_i (keep_ext[i]),
      .prev_valid_i(valid_ext[(i == 0) ? 0 : i - 1]),
      .prev_entry_i(entry_ext[(i == 0) ? 0 : i - 1]),
      .next_valid_i(valid_ext[i+1]),
      .next_entry_i(entry_ext[i+1]),
      .keep_o      (keep_ext[i+1]),
      .valid_o     (valid_ext[i]),
      .entry_o     (entry_ext[i])
    );
  end

  assign base_eff = first_q ? entry_ext[0].llr : base_q;

  assign out_word_o.symbol   = entry_ext[0].sym;
  assign out_word_o.norm_llr = LLR_W'(entry_ext[0].llr - base_eff);
  assign out_word_o.last_out = out_last;

  always_comb begin
    state_d    = state_q;
    sym_cnt_d  = sym_cnt_q;
    emit_cnt_d = emit_cnt_q;
    first_d    = first_q;
    base_d     = base_q;
    unique case (state_q)
      ST_FILL: begin
        if (do_insert) begin
          sym_cnt_d = sym_cnt_q + CNT_W'(1);
        end
        if (accept_in && in_word_i.is_last) begin
          sym_cnt_d = '0;
          if (do_insert || valid_ext[0]) begin
            state_d    = ST_EMIT;
            emit_cnt_d = '0;
            first_d    = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (accept_out) begin
          if (out_last) begin
            state_d = ST_FILL;
          end else begin
            emit_cnt_d = emit_cnt_q + CAP_W'(1);
            first_d    = 1'b0;
            base_d     = base_eff;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q <= KEEP_RST;
      state_q      <= ST_FILL;
      sym_cnt_q    <= '0;
      emit_cnt_q   <= '0;
      first_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        keep_count_q <= cfg_wdata_i;
      end
      state_q    <= state_d;
      sym_cnt_q  <= sym_cnt_d;
      emit_cnt_q <= emit_cnt_d;
      first_q    <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
  end

  `LLRK_ASSERT(a_valid_packed, (((valid_ext[MAX_KEEP-1:0] + 1'b1) & valid_ext[MAX_KEEP-1:0]) == '0), "kept entries are not packed at the head of the row")
  `LLRK_ASSERT_IMPL(a_emit_head, (state_q == ST_EMIT), valid_ext[0], "emitting from an empty row")
  `LLRK_ASSERT_IMPL(a_emit_cnt, (state_q == ST_EMIT), (emit_cnt_q < cap), "more words emitted than the capacity")
  `LLRK_ASSERT_NEXT(a_clear_done, (accept_out && out_last), ((state_q == ST_FILL) && (valid_ext == '0) && (sym_cnt_q == '0)), "row not cleared after the final word")

endmodule

/* hw/rtl/llrk_cell.sv */
// One cell of the sorted chain: holds one kept entry and its valid bit.
module llrk_cell import llrk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  logic       in_cap_i,
  input  logic       prev_keep_i,
  input  logic       prev_valid_i,
  input  entry_t     prev_entry_i,
  input  logic       next_valid_i,
  input  entry_t     next_entry_i,
  output logic       keep_o,
  output logic       valid_o,
  output entry_t     entry_o
);

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   keep;

  // Equal values stay put, so a newer symbol lands behind them.
  assign keep = valid_q && (entry_q.llr <= new_i.llr);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end else if (ctrl_i.insert) begin
      if (!in_cap_i) begin
        valid_d = 1'b0;
      end else if (!keep) begin
        if (prev_keep_i) begin
          valid_d = 1'b1;
          entry_d = new_i;
        end else begin
          valid_d = prev_valid_i;
          entry_d = prev_entry_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign keep_o  = keep;
  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule
